// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by binomial_tree_children.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/btc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// btc_pkg
// Types, constants and helpers for the binomial tree children block.
// ---------------------------------------------------------------------------
package btc_pkg;

  localparam int RANK_BITS   = 16;
  localparam int SIZE_BITS   = RANK_BITS + 1;
  localparam int NUM_CELLS   = RANK_BITS;
  localparam int ORDER_BITS  = 4;
  localparam int HEIGHT_BITS = $clog2(RANK_BITS + 1);

  localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1) << RANK_BITS;

  // Bisection range of the item travelling down the chain
  typedef struct packed {
    logic                 valid;
    logic [RANK_BITS-1:0] rank;
    logic [RANK_BITS-1:0] low;
    logic [RANK_BITS-1:0] high;
  } btc_tok_t;

  // Child found by a cell in the current cycle
  typedef struct packed {
    logic                 valid;
    logic [RANK_BITS-1:0] child;
    logic                 last;
  } btc_emit_t;

  // Bit length of a value, i.e. ceil(log2(v + 1))
  function automatic logic [HEIGHT_BITS-1:0] btc_bitlen(input logic [RANK_BITS-1:0] v);
    logic [HEIGHT_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < RANK_BITS; i++) begin
      if (v[i]) begin
        h = HEIGHT_BITS'(i + 1);
      end
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// File: design/btc_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// btc_cell
// One bisection step of the chain: reports a child when the lower bound
// sits on the rank, narrows the range and hands it to the next cell.
// ---------------------------------------------------------------------------
module btc_cell import btc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire btc_tok_t  tok_in,
  output btc_tok_t       tok_out,
  output btc_emit_t      emit
);

  btc_tok_t               tok;
  btc_tok_t               tok_next;
  logic [RANK_BITS-1:0]   diff;
  logic [RANK_BITS-1:0]   mid;

  // Split point, rounded up
  always_comb begin
    diff = tok_in.high - tok_in.low;
    mid  = tok_in.low + (diff >> 1) + RANK_BITS'(diff[0]);
  end

  // Child report; the last one leaves a single rank behind
  always_comb begin
    emit.valid = tok_in.valid && (tok_in.low == tok_in.rank);
    emit.child = mid;
    emit.last  = (diff <= RANK_BITS'(2));
  end

  // Narrow the range; the item drops out once one rank is left
  always_comb begin
    tok_next = tok_in;
    if (mid <= tok_in.rank) begin
      tok_next.low = mid;
    end else begin
      tok_next.high = mid - RANK_BITS'(1);
    end
    tok_next.valid = tok_in.valid && (tok_next.low != tok_next.high);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule
`default_nettype wire

// File: design/binomial_tree_children.sv
`default_nettype none
// ---------------------------------------------------------------------------
// binomial_tree_children
// Lists the children of a rank in a binomial broadcast tree over the group
// set in the size register, one bisection cell per tree level.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  cfg       in         cfg_we             group_size
//  in        in         in_valid/in_stall  node_rank
//  out       out        out_valid/out_stall child_rank, child_order,
//                                          last_child, tree_height
//
// An item sits in the entry register, then moves one cell per cycle
// down the chain of bisection cells, unless the chain is held, until its
// range holds one rank. A new item is taken once the chain is empty; the
// output register may still hold a child then. A child that meets a full,
// stalled output register holds the whole chain until the output is taken.
// Reset is synchronous; the size register returns to one node.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module binomial_tree_children import btc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [SIZE_BITS-1:0]   group_size,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [RANK_BITS-1:0]   node_rank,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [RANK_BITS-1:0]        child_rank,
  output logic [ORDER_BITS-1:0]       child_order,
  output logic                        last_child,
  output logic [HEIGHT_BITS-1:0]      tree_height
);

  // Configuration derived from the group size
  logic                   cfg_empty;
  logic [RANK_BITS-1:0]   cfg_high;
  logic [HEIGHT_BITS-1:0] cfg_height;
  logic [SIZE_BITS-1:0]   size_sat;
  logic [RANK_BITS-1:0]   size_high;

  btc_tok_t               entry;
  btc_tok_t               chain [NUM_CELLS];
  btc_emit_t              emits [NUM_CELLS];
  logic [NUM_CELLS-1:0]   tok_vec;
  logic [NUM_CELLS-1:0]   emit_vec;
  logic                   emit_any;
  logic [RANK_BITS-1:0]   emit_child;
  logic                   emit_last;
  logic                   adv;
  logic                   in_acc;
  logic [ORDER_BITS-1:0]  order;

  // Saturate the size and precompute range top and height
  always_comb begin
    size_sat  = (group_size > SIZE_CAP) ? SIZE_CAP : group_size;
    size_high = RANK_BITS'(size_sat - SIZE_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_empty  <= 1'b0;
      cfg_high   <= '0;
      cfg_height <= '0;
    end else if (cfg_we) begin
      cfg_empty  <= (size_sat == '0);
      cfg_high   <= size_high;
      cfg_height <= btc_bitlen(size_high);
    end
  end

  // Entry register: accepts an item once the chain is empty
  assign in_stall = entry.valid || (|tok_vec);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (in_acc) begin
      entry.valid <= !cfg_empty && (node_rank <= cfg_high) && (cfg_high != '0);
      entry.rank  <= node_rank;
      entry.low   <= '0;
      entry.high  <= cfg_high;
    end else if (adv) begin
      entry.valid <= 1'b0;
    end
  end

  // Chain of bisection cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    btc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  ((g == 0) ? entry : chain[(g == 0) ? 0 : g - 1]),
      .tok_out (chain[g]),
      .emit    (emits[g])
    );
  end

  // Gather the single child reported this cycle
  always_comb begin
    emit_any   = 1'b0;
    emit_child = '0;
    emit_last  = 1'b0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      tok_vec[i]  = chain[i].valid;
      emit_vec[i] = emits[i].valid;
      if (emits[i].valid) begin
        emit_any   = 1'b1;
        emit_child = emit_child | emits[i].child;
        emit_last  = emit_last | emits[i].last;
      end
    end
  end

  // Chain moves unless a child is waiting on a full, stalled output
  assign adv = !emit_any || !out_valid || !out_stall;

  // Output register and child counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      order     <= '0;
    end else begin
      if (in_acc) begin
        order <= '0;
      end else if (emit_any && adv) begin
        order <= order + ORDER_BITS'(1);
      end
      if (emit_any && adv) begin
        out_valid   <= 1'b1;
        child_rank  <= emit_child;
        child_order <= order;
        last_child  <= emit_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tree_height = cfg_height;

  // Checks
  `ASSERT_ALWAYS(a_one_emit, $onehot0(emit_vec))
  `ASSERT_ALWAYS(a_one_item, $onehot0({entry.valid, tok_vec}))
  `ASSERT_NEXT(a_hold_chain, !adv, $stable(tok_vec) && $stable(entry.valid))

endmodule
`default_nettype wire

// File: bench/binomial_tree_children_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// binomial_tree_children_tb
// Self-checking bench for the binomial tree children block. A short table of
// requests covers the size extremes, empty and oversized groups, leaves and
// ranks outside the group; random requests over a series of sizes follow.
// Expected children come from the answer typed in a table row or else from
// a bisection predictor held in the bench; children are checked in order,
// field by field, as they are accepted from the output.
// ---------------------------------------------------------------------------
module binomial_tree_children_tb;
  import btc_pkg::*;

  localparam int SETTLE       = 40;    // idle cycles after the expected children drain
  localparam int QUIET_LIMIT  = 4000;  // cycles without any item moving
  localparam int RANDOM_ITEMS = 350;
  localparam int PHASE_ITEMS  = 35;
  localparam int PLAN_LEN     = 28;

  // One expected or observed child
  typedef struct packed {
    logic [RANK_BITS-1:0]   rank;
    logic [ORDER_BITS-1:0]  order;
    logic                   last;
    logic [HEIGHT_BITS-1:0] height;
  } child_t;

  typedef enum logic [1:0] {ROW_SIZE, ROW_ASK, ROW_KNOWN} row_kind_t;

  // ROW_SIZE writes value as group size; the others request rank value,
  // ROW_KNOWN with the answer typed in (no child, or the one child given)
  typedef struct packed {
    row_kind_t            kind;
    logic [SIZE_BITS-1:0] value;
    logic                 has_child;
    child_t               child;
  } plan_row_t;

  localparam child_t NO_CHILD = '0;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [SIZE_BITS-1:0]   group_size = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [RANK_BITS-1:0]   node_rank  = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [RANK_BITS-1:0]   child_rank;
  logic [ORDER_BITS-1:0]  child_order;
  logic                   last_child;
  logic [HEIGHT_BITS-1:0] tree_height;

  child_t               pending_children[$];
  logic [SIZE_BITS-1:0] size_mirror   = SIZE_BITS'(1);
  int                   errors        = 0;
  int                   stall_left    = 0;
  int                   quiet_cycles  = 0;
  bit                   tx_quiet      = 1'b0;
  bit                   rx_quiet      = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    // reset size of one: a lone root, and a rank far outside
    '{ROW_KNOWN, 17'd0,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd65535,  1'b0, NO_CHILD},
    // empty group
    '{ROW_SIZE,  17'd0,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd0,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd65535,  1'b0, NO_CHILD},
    // two and three nodes
    '{ROW_SIZE,  17'd2,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd0,      1'b1, '{16'd1, 4'd0, 1'b1, 5'd1}},
    '{ROW_KNOWN, 17'd1,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd2,      1'b0, NO_CHILD},
    '{ROW_SIZE,  17'd3,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd0,      1'b1, '{16'd1, 4'd0, 1'b1, 5'd2}},
    '{ROW_ASK,   17'd1,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd2,      1'b0, NO_CHILD},
    // full group: root with sixteen children, an inner node, leaves
    '{ROW_SIZE,  17'd65536,  1'b0, NO_CHILD},
    '{ROW_ASK,   17'd0,      1'b0, NO_CHILD},
    '{ROW_ASK,   17'd32768,  1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd65534,  1'b1, '{16'd65535, 4'd0, 1'b1, 5'd16}},
    '{ROW_KNOWN, 17'd65535,  1'b0, NO_CHILD},
    // oversized group saturates to the full group
    '{ROW_SIZE,  17'h1FFFF,  1'b0, NO_CHILD},
    '{ROW_ASK,   17'd0,      1'b0, NO_CHILD},
    '{ROW_KNOWN, 17'd65534,  1'b1, '{16'd65535, 4'd0, 1'b1, 5'd16}},
    '{ROW_KNOWN, 17'd65535,  1'b0, NO_CHILD},
    '{ROW_SIZE,  17'd65537,  1'b0, NO_CHILD},
    '{ROW_ASK,   17'd43690,  1'b0, NO_CHILD},
    // one short of the full group
    '{ROW_SIZE,  17'd65535,  1'b0, NO_CHILD},
    '{ROW_ASK,   17'd0,      1'b0, NO_CHILD},
    '{ROW_ASK,   17'd65534,  1'b0, NO_CHILD},
    '{ROW_ASK,   17'd21845,  1'b0, NO_CHILD}
  };

  binomial_tree_children dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .group_size  (group_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .node_rank   (node_rank),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .child_rank  (child_rank),
    .child_order (child_order),
    .last_child  (last_child),
    .tree_height (tree_height)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bisect [0, size-1] and queue every child split off at the rank
  function automatic void predict_children(input logic [SIZE_BITS-1:0] size_reg,
                                           input logic [RANK_BITS-1:0] rank);
    int     sz, lo, hi, mid, diff, height, span, k;
    int     kids[$];
    child_t c;
    sz = (size_reg > SIZE_CAP) ? int'(SIZE_CAP) : int'(size_reg);
    if (sz == 0 || int'(rank) >= sz) return;
    height = 0;
    span   = 1;
    while (span < sz) begin
      span   = span << 1;
      height = height + 1;
    end
    lo = 0;
    hi = sz - 1;
    while (hi > lo && kids.size() < 16) begin
      diff = hi - lo;
      mid  = lo + (diff >> 1) + (diff & 1);
      if (lo == int'(rank)) kids.push_back(mid);
      if (mid <= int'(rank)) lo = mid;
      else hi = mid - 1;
    end
    for (k = 0; k < kids.size(); k++) begin
      c.rank   = RANK_BITS'(kids[k]);
      c.order  = ORDER_BITS'(k);
      c.last   = (k == kids.size() - 1);
      c.height = HEIGHT_BITS'(height);
      pending_children.push_back(c);
    end
  endfunction

  // Offer one rank after a random gap and queue what it should produce
  task automatic send_rank(input logic [RANK_BITS-1:0] rank, input bit typed,
                           input logic has_child, input child_t known);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    node_rank <= rank;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      if (has_child) pending_children.push_back(known);
    end else begin
      predict_children(size_mirror, rank);
    end
  endtask

  // Stop offering, let every expected child drain, then settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_children.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Size register is only touched with the chain empty
  task automatic write_size(input logic [SIZE_BITS-1:0] value);
    wait_idle(SETTLE);
    cfg_we     <= 1'b1;
    group_size <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    size_mirror = value;
  endtask

  // Output side: random stall after each item, check against oldest child
  always @(posedge clk) begin
    child_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_children.size() == 0) begin
          $error("unexpected child: rank %0d order %0d", child_rank, child_order);
          errors = errors + 1;
        end else begin
          want = pending_children.pop_front();
          if (child_rank !== want.rank) begin
            $error("child_rank: expected %0d, got %0d", want.rank, child_rank);
            errors = errors + 1;
          end
          if (child_order !== want.order) begin
            $error("child_order: expected %0d, got %0d", want.order, child_order);
            errors = errors + 1;
          end
          if (last_child !== want.last) begin
            $error("last_child: expected %0d, got %0d", want.last, last_child);
            errors = errors + 1;
          end
          if (tree_height !== want.height) begin
            $error("tree_height: expected %0d, got %0d", want.height, tree_height);
            errors = errors + 1;
          end
        end
        stall_left = rx_quiet ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: give up when no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                   row, sent, eff, pick;
    logic [SIZE_BITS-1:0] sz;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (row = 0; row < PLAN_LEN; row++) begin
      case (plan[row].kind)
        ROW_SIZE:  write_size(plan[row].value);
        ROW_ASK:   send_rank(plan[row].value[RANK_BITS-1:0], 1'b0, 1'b0, NO_CHILD);
        ROW_KNOWN: send_rank(plan[row].value[RANK_BITS-1:0], 1'b1,
                             plan[row].has_child, plan[row].child);
        default:   ;
      endcase
    end

    // Random phases, each with its own size and idling pattern
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 7))
          0:       sz = SIZE_CAP;
          1:       sz = SIZE_BITS'($urandom_range(0, 131071));
          2:       sz = SIZE_BITS'($urandom_range(1, 8));
          3, 4:    sz = SIZE_BITS'($urandom_range(2, 64));
          5:       sz = SIZE_BITS'($urandom_range(65, 4096));
          6:       sz = SIZE_BITS'($urandom_range(4097, 65536));
          default: sz = $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
        endcase
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        write_size(sz);
      end
      // now and then hold off until the output has caught up
      if ($urandom_range(0, 19) == 0) wait_idle(0);
      eff = (size_mirror > SIZE_CAP) ? int'(SIZE_CAP) : int'(size_mirror);
      case ($urandom_range(0, 9))
        0:       pick = $urandom_range(0, 65535);
        1:       pick = (eff > 65535) ? 65535 : eff;
        default: begin
          pick = (eff == 0) ? $urandom_range(0, 65535) : $urandom_range(0, eff - 1);
          // clear low bits to favour ranks with many children
          if ($urandom_range(0, 2) != 0) pick = pick & ~((1 << $urandom_range(0, 16)) - 1);
        end
      endcase
      send_rank(RANK_BITS'(pick), 1'b0, 1'b0, NO_CHILD);
      sent = sent + 1;
    end

    wait_idle(SETTLE);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
